FILE: design/plpae_pkg.sv
// ----------------------------------------------------------------------------
// plpae_pkg
// Scanner geometry, field widths, status codes and the structs shared by the
// pair address encoder and its datapath.
// ----------------------------------------------------------------------------
package plpae_pkg;

	// scanner geometry
	localparam int unsigned MODULES           = 32;
	localparam int unsigned TRANSAXIAL        = 12;
	localparam int unsigned BLOCKS_PER_MODULE = 6;
	localparam int unsigned AXIAL_RINGS       = 72;
	localparam int unsigned RINGS_PER_BLOCK   =
		((AXIAL_RINGS / BLOCKS_PER_MODULE) > 0) ? (AXIAL_RINGS / BLOCKS_PER_MODULE) : 1;
	localparam int unsigned CRYSTALS_PER_MODULE = AXIAL_RINGS * TRANSAXIAL;
	localparam int unsigned BLOCK_CRYSTALS      = RINGS_PER_BLOCK * TRANSAXIAL;

	// reciprocal of the rings per block, rounded up, for the ring-to-block divide
	localparam int unsigned RECIP_SHIFT = 16;
	localparam int unsigned RING_RECIP  = ((1 << RECIP_SHIFT) / RINGS_PER_BLOCK) + 1;

	// field widths
	localparam int unsigned MOD_W    = 5;
	localparam int unsigned TRANS_W  = 4;
	localparam int unsigned RING_W   = 7;
	localparam int unsigned FAN_W    = 6;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PAIR_W   = 10;
	localparam int unsigned OFFSET_W = 20;
	localparam int unsigned INDEX_W  = 15;
	localparam int unsigned DIFF_W   = 7;
	localparam int unsigned CODE_W   = 10;

	localparam logic [FAN_W-1:0] FAN_RESET = FAN_W'(19);

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FAN   = 2'd2
	} status_t;

	// fan settings, derived once when the register is written
	typedef struct packed {
		logic             none;   // fan of zero: no pairs at all
		logic [FAN_W-1:0] fan;    // fan clipped to the module count
		logic [FAN_W-1:0] off;    // distance from a module to the first module of its fan
		logic [FAN_W-1:0] full;   // first modules whose fan is not cut at the last module
	} fan_cfg_t;

	typedef struct packed {
		logic [MOD_W-1:0]   module_a;
		logic [TRANS_W-1:0] trans_a;
		logic [RING_W-1:0]  ring_a;
		logic [MOD_W-1:0]   module_b;
		logic [TRANS_W-1:0] trans_b;
		logic [RING_W-1:0]  ring_b;
	} event_t;

	typedef struct packed {
		status_t             status;
		logic [PAIR_W-1:0]   pair_number;
		logic [OFFSET_W-1:0] pair_offset;
		logic [INDEX_W-1:0]  crystal_index_a;
		logic [INDEX_W-1:0]  crystal_index_b;
		logic [DIFF_W-1:0]   ring_difference;
	} result_t;

endpackage

FILE: design/plpae_calc.sv
// ----------------------------------------------------------------------------
// plpae_calc
// Combinational datapath: range check, fan check, closed-form pair number,
// crystal pair offset, flat crystal indices and true ring difference.
// ----------------------------------------------------------------------------
module plpae_calc (
	input  plpae_pkg::fan_cfg_t fan_cfg,
	input  plpae_pkg::event_t   ev,
	output plpae_pkg::result_t  res
);

	localparam int unsigned LIM_W = plpae_pkg::MOD_W + 2;
	localparam int unsigned PRD_W = 2 * plpae_pkg::FAN_W + 1;

	// ring / RINGS_PER_BLOCK by reciprocal multiply, one-step correction
	function automatic logic [plpae_pkg::RING_W-1:0] ring_block(
		input logic [plpae_pkg::RING_W-1:0] ring
	);
		int unsigned               p;
		logic [plpae_pkg::RING_W-1:0] q;
		p = 32'(ring) * plpae_pkg::RING_RECIP;
		q = plpae_pkg::RING_W'(p >> plpae_pkg::RECIP_SHIFT);
		if (32'(q) * plpae_pkg::RINGS_PER_BLOCK > 32'(ring)) begin
			q = q - plpae_pkg::RING_W'(1);
		end
		return q;
	endfunction

	function automatic logic [plpae_pkg::CODE_W-1:0] crystal_code(
		input logic [plpae_pkg::TRANS_W-1:0] trans,
		input logic [plpae_pkg::RING_W-1:0]  ring,
		input logic [plpae_pkg::RING_W-1:0]  blk
	);
		int unsigned rem;
		rem = 32'(ring) - 32'(blk) * plpae_pkg::RINGS_PER_BLOCK;
		return plpae_pkg::CODE_W'(32'(blk) * plpae_pkg::BLOCK_CRYSTALS
			+ plpae_pkg::RINGS_PER_BLOCK * (plpae_pkg::TRANSAXIAL - 1 - 32'(trans))
			+ (plpae_pkg::RINGS_PER_BLOCK - 1 - rem));
	endfunction

	function automatic logic [plpae_pkg::INDEX_W-1:0] flat_index(
		input logic [plpae_pkg::MOD_W-1:0]   module_n,
		input logic [plpae_pkg::TRANS_W-1:0] trans,
		input logic [plpae_pkg::RING_W-1:0]  ring
	);
		return plpae_pkg::INDEX_W'(32'(module_n) * plpae_pkg::CRYSTALS_PER_MODULE
			+ plpae_pkg::TRANSAXIAL * 32'(ring) + 32'(trans));
	endfunction

	logic                               range_err;
	logic [plpae_pkg::RING_W-1:0]       blk_a, blk_b;
	logic [plpae_pkg::CODE_W-1:0]       code_a, code_b;
	logic [plpae_pkg::RING_W:0]         true_a, true_b, diff;
	logic [LIM_W-1:0]                   mod_b_ext, lo_lim, hi_lim, rel;
	logic                               in_fan;
	logic [plpae_pkg::FAN_W-1:0]        mod_a_ext, n_full, j_raw, j_c;
	logic [plpae_pkg::FAN_W:0]          span;
	logic [2*plpae_pkg::FAN_W-1:0]      term_full;
	logic [PRD_W-1:0]                   tri_prod;
	logic [plpae_pkg::PAIR_W-1:0]       pair_sum;

	always_comb begin
		range_err = (32'(ev.module_a) >= plpae_pkg::MODULES)
			|| (32'(ev.module_b) >= plpae_pkg::MODULES)
			|| (32'(ev.trans_a) >= plpae_pkg::TRANSAXIAL)
			|| (32'(ev.trans_b) >= plpae_pkg::TRANSAXIAL)
			|| (32'(ev.ring_a) >= plpae_pkg::AXIAL_RINGS)
			|| (32'(ev.ring_b) >= plpae_pkg::AXIAL_RINGS);

		blk_a  = ring_block(ev.ring_a);
		blk_b  = ring_block(ev.ring_b);
		code_a = crystal_code(ev.trans_a, ev.ring_a, blk_a);
		code_b = crystal_code(ev.trans_b, ev.ring_b, blk_b);

		// one gap ring after every axial block
		true_a = (plpae_pkg::RING_W+1)'(ev.ring_a) + (plpae_pkg::RING_W+1)'(blk_a);
		true_b = (plpae_pkg::RING_W+1)'(ev.ring_b) + (plpae_pkg::RING_W+1)'(blk_b);
		diff   = (true_a >= true_b) ? (true_a - true_b) : (true_b - true_a);

		// second module must lie in [a+off, a+off+fan)
		mod_b_ext = LIM_W'(ev.module_b);
		lo_lim    = LIM_W'(ev.module_a) + LIM_W'(fan_cfg.off);
		hi_lim    = lo_lim + LIM_W'(fan_cfg.fan);
		in_fan    = !fan_cfg.none && (mod_b_ext >= lo_lim) && (mod_b_ext < hi_lim);
		rel       = mod_b_ext - lo_lim;

		// pairs owned by the modules below module_a: full fans first, then a
		// run that shrinks by one module each step (fan-1, fan-2, ...)
		mod_a_ext = plpae_pkg::FAN_W'(ev.module_a);
		n_full    = (mod_a_ext < fan_cfg.full) ? mod_a_ext : fan_cfg.full;
		j_raw     = (mod_a_ext > fan_cfg.full) ? (mod_a_ext - fan_cfg.full) : '0;
		j_c       = (j_raw > fan_cfg.fan) ? fan_cfg.fan : j_raw;
		span      = {fan_cfg.fan, 1'b0} - (plpae_pkg::FAN_W+1)'(j_c)
			- (plpae_pkg::FAN_W+1)'(1);
		term_full = (2*plpae_pkg::FAN_W)'(n_full) * (2*plpae_pkg::FAN_W)'(fan_cfg.fan);
		tri_prod  = PRD_W'(j_c) * PRD_W'(span);
		pair_sum  = plpae_pkg::PAIR_W'(term_full)
			+ plpae_pkg::PAIR_W'(tri_prod >> 1)
			+ plpae_pkg::PAIR_W'(rel);

		if (range_err) begin
			res = '0;
			res.status = plpae_pkg::STATUS_RANGE;
		end else begin
			res.status          = in_fan ? plpae_pkg::STATUS_OK : plpae_pkg::STATUS_FAN;
			res.pair_number     = in_fan ? pair_sum : '0;
			res.pair_offset     = plpae_pkg::OFFSET_W'(32'(code_a)
				* plpae_pkg::CRYSTALS_PER_MODULE + 32'(code_b));
			res.crystal_index_a = flat_index(ev.module_a, ev.trans_a, ev.ring_a);
			res.crystal_index_b = flat_index(ev.module_b, ev.trans_b, ev.ring_b);
			res.ring_difference = plpae_pkg::DIFF_W'(diff);
		end
	end

endmodule

FILE: design/pet_lor_pair_address_encoder.sv
// ----------------------------------------------------------------------------
// pet_lor_pair_address_encoder
// Flow: an accepted request is held in the input register, passes once
// through the datapath, and its result is captured in the result register.
// Throughput: one request per cycle while out_ready is high; the result register frees as it is taken.
// Reset: both stages empty, fan_size back to 19.
// ----------------------------------------------------------------------------
module pet_lor_pair_address_encoder (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_we,
	input  logic [plpae_pkg::FAN_W-1:0]       cfg_wdata,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [plpae_pkg::MOD_W-1:0]       module_a,
	input  logic [plpae_pkg::TRANS_W-1:0]     trans_a,
	input  logic [plpae_pkg::RING_W-1:0]      ring_a,
	input  logic [plpae_pkg::MOD_W-1:0]       module_b,
	input  logic [plpae_pkg::TRANS_W-1:0]     trans_b,
	input  logic [plpae_pkg::RING_W-1:0]      ring_b,

	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [plpae_pkg::STATUS_W-1:0]    status,
	output logic [plpae_pkg::PAIR_W-1:0]      pair_number,
	output logic [plpae_pkg::OFFSET_W-1:0]    pair_offset,
	output logic [plpae_pkg::INDEX_W-1:0]     crystal_index_a,
	output logic [plpae_pkg::INDEX_W-1:0]     crystal_index_b,
	output logic [plpae_pkg::DIFF_W-1:0]      ring_difference
);

	// clip the fan and work out the fan offset and full-fan count
	function automatic plpae_pkg::fan_cfg_t fan_derive(
		input logic [plpae_pkg::FAN_W-1:0] fan_size
	);
		plpae_pkg::fan_cfg_t c;
		int unsigned         f;
		int unsigned         o;
		f      = (32'(fan_size) > plpae_pkg::MODULES) ? plpae_pkg::MODULES : 32'(fan_size);
		o      = (plpae_pkg::MODULES + 1 - f) >> 1;
		c.none = (f == 0);
		c.fan  = plpae_pkg::FAN_W'(f);
		c.off  = plpae_pkg::FAN_W'(o);
		c.full = plpae_pkg::FAN_W'(plpae_pkg::MODULES + 1 - o - f);
		return c;
	endfunction

	plpae_pkg::fan_cfg_t fan_cfg_q;
	logic                valid_s1, valid_s2;
	plpae_pkg::event_t   event_s1;
	plpae_pkg::result_t  result_s2;
	plpae_pkg::result_t  result_c;
	logic                load_s2;

	// advance stage 1 whenever the result register is empty or being taken
	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_cfg_q <= fan_derive(plpae_pkg::FAN_RESET);
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (cfg_we) begin
				fan_cfg_q <= fan_derive(cfg_wdata);
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			event_s1 <= '{module_a: module_a, trans_a: trans_a, ring_a: ring_a,
				module_b: module_b, trans_b: trans_b, ring_b: ring_b};
		end
		if (load_s2) begin
			result_s2 <= result_c;
		end
	end

	plpae_calc u_calc (
		.fan_cfg (fan_cfg_q),
		.ev      (event_s1),
		.res     (result_c)
	);

	assign out_valid       = valid_s2;
	assign status          = result_s2.status;
	assign pair_number     = result_s2.pair_number;
	assign pair_offset     = result_s2.pair_offset;
	assign crystal_index_a = result_s2.crystal_index_a;
	assign crystal_index_b = result_s2.crystal_index_b;
	assign ring_difference = result_s2.ring_difference;

endmodule
